// ===== design/preemptive_priority_scheduler_defines.svh =====
// Assertion macros used by the scheduler datapath.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pps_pkg.sv =====
package pps_pkg;

    localparam int SLOTS_DEF  = 4;
    localparam int SLOT_FW    = 2;
    localparam int TIME_W     = 16;
    localparam int BURST_W    = 16;
    localparam int PRIO_W     = 8;
    localparam int TURN_W     = 17;
    localparam int WAIT_W     = 16;
    localparam int SUM_W      = 32;
    localparam int SUM_XW     = SUM_W + 1;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 120;
    localparam int OUT_PAD_W  = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum logic [0:0] {
        KIND_LOAD = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_SERVE,
        ST_WAIT,
        ST_TOTAL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [TIME_W-1:0]  arrival;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] remaining;
    } t_task;

    typedef struct packed {
        logic start;
        logic load;
        logic scan;
        logic serve;
        logic calc_wait;
        logic total;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_status;

endpackage

// ===== design/pps_ctrl.sv =====
module pps_ctrl
    import pps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_kind   i_in_kind,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_kind == KIND_TICK) ? ST_SCAN : ST_LOAD;
                end
            end
            ST_LOAD:  n_state = ST_OUT;
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_SERVE;
                end
            end
            ST_SERVE: n_state = ST_WAIT;
            ST_WAIT:  n_state = ST_TOTAL;
            ST_TOTAL: n_state = ST_OUT;
            ST_OUT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
            end
            ST_LOAD:  o_cmd.load      = 1'b1;
            ST_SCAN:  o_cmd.scan      = 1'b1;
            ST_SERVE: o_cmd.serve     = 1'b1;
            ST_WAIT:  o_cmd.calc_wait = 1'b1;
            ST_TOTAL: o_cmd.total     = 1'b1;
            ST_OUT:   o_cmd.out_load  = i_status.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

// ===== design/pps_datapath.sv =====
`include "preemptive_priority_scheduler_defines.svh"

module pps_datapath
    import pps_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  t_kind                 i_in_kind,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    // captured item
    t_kind               r_kind;
    logic [SLOT_FW-1:0]  r_slot;
    logic [TIME_W-1:0]   r_arrival;
    logic [BURST_W-1:0]  r_burst;
    logic [PRIO_W-1:0]   r_prio;

    // task table and per-slot busy bits
    t_task               r_mem [SLOTS];
    logic [SLOTS-1:0]    r_busy, n_busy;

    // scan
    logic [CW-1:0]       r_idx;
    t_task               r_rd;
    logic [AW-1:0]       r_rd_idx;
    logic                r_rd_valid;
    logic                r_found;
    logic [AW-1:0]       r_best_idx;
    t_task               r_best;

    // per-item results and running state
    logic                r_ran_valid;
    logic [SLOT_FW-1:0]  r_ran_slot;
    logic                r_finished;
    logic [TURN_W-1:0]   r_turn;
    logic [WAIT_W-1:0]   r_wait;
    logic [TIME_W-1:0]   r_tick;
    logic [SUM_W-1:0]    r_wait_total;
    logic [SUM_W-1:0]    r_turn_total;
    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                load_hit;
    logic [AW-1:0]       load_addr;
    logic                scan_rd;
    logic                eligible;
    logic                better;
    logic                finishing;
    t_task               served;
    logic [TURN_W-1:0]   turn_calc;
    logic [WAIT_W-1:0]   wait_calc;
    logic [SUM_XW-1:0]   wsum;
    logic [SUM_XW-1:0]   tsum;
    logic [TIME_W-1:0]   tick_next;

    assign load_hit  = 32'(r_slot) < SLOTS;
    assign load_addr = AW'(r_slot);
    assign scan_rd   = i_cmd.scan && (r_idx < CW'(SLOTS));

    assign eligible = r_rd_valid && r_busy[r_rd_idx] && (r_rd.arrival <= r_tick);
    assign better   = !r_found || (r_rd.prio < r_best.prio) ||
                      ((r_rd.prio == r_best.prio) && (r_rd.arrival < r_best.arrival));

    assign finishing = r_found && (r_best.remaining == BURST_W'(1));
    always_comb begin
        served           = r_best;
        served.remaining = r_best.remaining - BURST_W'(1);
    end

    assign turn_calc = TURN_W'(r_tick) + TURN_W'(1) - TURN_W'(r_best.arrival);
    assign wait_calc = (r_turn > TURN_W'(r_best.burst)) ?
                       WAIT_W'(r_turn - TURN_W'(r_best.burst)) : '0;

    assign wsum = {1'b0, r_wait_total} + SUM_XW'(r_wait);
    assign tsum = {1'b0, r_turn_total} + SUM_XW'(r_turn);

    assign tick_next = ((r_kind == KIND_TICK) && (r_tick != TIME_MAX)) ?
                       r_tick + TIME_W'(1) : r_tick;

    always_comb begin
        n_busy = r_busy;
        if (i_cmd.load && load_hit) begin
            n_busy[load_addr] = (r_burst != '0);
        end
        if (i_cmd.serve && finishing) begin
            n_busy[r_best_idx] = 1'b0;
        end
    end

    // table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && load_hit) begin
            r_mem[load_addr] <= '{prio: r_prio, arrival: r_arrival,
                                  burst: r_burst, remaining: r_burst};
        end else if (i_cmd.serve && r_found) begin
            r_mem[r_best_idx] <= served;
        end
        if (scan_rd) begin
            r_rd     <= r_mem[r_idx[AW-1:0]];
            r_rd_idx <= r_idx[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= '0;
            r_tick       <= '0;
            r_wait_total <= '0;
            r_turn_total <= '0;
            r_out_valid  <= 1'b0;
            r_rd_valid   <= 1'b0;
            r_found      <= 1'b0;
            r_idx        <= '0;
            r_ran_valid  <= 1'b0;
            r_finished   <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_rd_valid <= scan_rd;
            if (i_cmd.start) begin
                r_idx       <= '0;
                r_found     <= 1'b0;
                r_ran_valid <= 1'b0;
                r_finished  <= 1'b0;
            end else if (scan_rd) begin
                r_idx <= r_idx + CW'(1);
            end
            if (eligible && better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.serve && r_found) begin
                r_ran_valid <= 1'b1;
                r_finished  <= finishing;
            end
            if (i_cmd.total && r_finished) begin
                r_wait_total <= wsum[SUM_W] ? '1 : wsum[SUM_W-1:0];
                r_turn_total <= tsum[SUM_W] ? '1 : tsum[SUM_W-1:0];
            end
            if (i_cmd.out_load) begin
                r_tick      <= tick_next;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind     <= i_in_kind;
            r_slot     <= i_in_data[SLOT_FW-1:0];
            r_arrival  <= i_in_data[SLOT_FW +: TIME_W];
            r_burst    <= i_in_data[SLOT_FW+TIME_W +: BURST_W];
            r_prio     <= i_in_data[SLOT_FW+TIME_W+BURST_W +: PRIO_W];
            r_ran_slot <= '0;
            r_turn     <= '0;
            r_wait     <= '0;
        end
        if (eligible && better) begin
            r_best     <= r_rd;
            r_best_idx <= r_rd_idx;
        end
        if (i_cmd.serve && r_found) begin
            r_ran_slot <= SLOT_FW'(r_best_idx);
            r_turn     <= finishing ? turn_calc : '0;
        end
        if (i_cmd.calc_wait && r_finished) begin
            r_wait <= wait_calc;
        end
        if (i_cmd.out_load) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, r_turn_total, r_wait_total, tick_next,
                           ~|r_busy, r_wait, r_turn, r_finished, r_ran_slot, r_ran_valid};
        end
    end

    assign o_status.scan_done = (r_idx == CW'(SLOTS)) && !r_rd_valid;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out_data;

    `PPS_ASSERT_NOW(a_out_no_overwrite, i_cmd.out_load, !r_out_valid || i_out_ready, "result register overwritten while pending")
    `PPS_ASSERT_NOW(a_finish_has_run, r_finished, r_ran_valid, "task finished without service")
    `PPS_ASSERT_NEXT(a_finish_clears_busy, i_cmd.serve && finishing, !r_busy[$past(r_best_idx)], "finished slot still busy")
    `PPS_ASSERT_NEXT(a_tick_monotonic, 1'b1, r_tick >= $past(r_tick), "tick count moved backward")

endmodule

// ===== design/preemptive_priority_scheduler.sv =====
// Load transaction: after acceptance the item is captured, the table is written, then the result is registered.
// Tick transaction: the scan reads one table entry per cycle through the single read
// port, then serve, waiting, totals, result.
// One transaction in flight; the next is accepted while a result waits in the output register.
// Reset (i_rst_n low, synchronous): all slots empty, time and totals zero, no result pending.
module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [1:0] slot, [17:2] arrival, [33:18] burst, [41:34] priority_req, [47:42] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] kind
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] ran_valid, [2:1] ran_slot, [3] finished, [20:4] turnaround, [36:21] waiting,
    // [37] all_done, [53:38] time_now, [85:54] wait_sum, [117:86] turnaround_sum,
    // [119:118] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cmd    cmd;
    t_status status;
    t_kind   in_kind;

    // tuser carries the transaction kind: load a slot or advance one tick
    assign in_kind = t_kind'(s_axis_tuser);

    // sequencer: accept, then load or scan/serve/account, then hand over the result
    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (in_kind),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // task table, best-slot search, completion math and output register
    pps_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (s_axis_tdata),
        .i_in_kind   (in_kind),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule
